FILE: hw/rtl/tar_pkg.sv
// Shared types, state and action codes, and sequence-space compares for the
// TCP ACK receive step. No dependencies.
`default_nettype none

package tar_pkg;

    // Connection state codes
    localparam logic [3:0] ST_CLOSED     = 4'd0;
    localparam logic [3:0] ST_SYN_RECV   = 4'd1;
    localparam logic [3:0] ST_ESTAB      = 4'd2;
    localparam logic [3:0] ST_FIN_WAIT1  = 4'd3;
    localparam logic [3:0] ST_FIN_WAIT2  = 4'd4;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd5;
    localparam logic [3:0] ST_CLOSING    = 4'd6;
    localparam logic [3:0] ST_LAST_ACK   = 4'd7;
    localparam logic [3:0] ST_TIME_WAIT  = 4'd8;

    // Routing actions
    localparam logic [2:0] ACT_DROP = 3'd0;
    localparam logic [2:0] ACT_PASS = 3'd1;
    localparam logic [2:0] ACT_RTR  = 3'd2;
    localparam logic [2:0] ACT_RST  = 3'd3;
    localparam logic [2:0] ACT_ACK  = 3'd4;

    // Operation codes
    localparam logic OP_SEGMENT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_SCALE = 2'd0;
    localparam logic [1:0] CFG_PASSIVE_OPEN = 2'd1;
    localparam logic [1:0] CFG_REINIT_RTO   = 2'd2;

    localparam logic [3:0] MAX_WSCALE = 4'd14;

    typedef struct packed {
        logic [3:0] window_scale;
        logic       passive_open;
        logic       reinit_rto;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  tcp_state;
        logic [31:0] snd_una;
        logic [29:0] snd_wnd;
        logic [31:0] wl1;
        logic [31:0] wl2;
        logic [29:0] wnd_max;
        logic        ce_seen;
    } conn_t;

    typedef struct packed {
        logic        operation;
        logic        ack_flag;
        logic        ecn_ce;
        logic        fin_flag;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] window_field;
        logic [31:0] snd_next;
        logic        parent_present;
        logic [3:0]  load_state;
    } seg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        ack_ece_request;
        logic [31:0] bytes_acked;
        logic [3:0]  conn_state;
        logic [29:0] send_window;
        logic [29:0] send_window_max;
        logic        clean_rtx;
        logic        time_wait_timer;
        logic        release_conn;
        logic        established_notify;
        logic        rto_reinit;
    } result_t;

    // a < b modulo 2^32
    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic logic seq_leq(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_lt(a, b);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tar_step.sv
// Combinational ACK processing for one beat: next connection state and result.
// Depends on tar_pkg.
`default_nettype none

module tar_step (
    input  var tar_pkg::cfg_t    cfg,
    input  var tar_pkg::conn_t   cur,
    input  var tar_pkg::seg_t    seg,
    output tar_pkg::conn_t       nxt,
    output tar_pkg::result_t     res
);

    logic [3:0]  shift;
    logic [29:0] scaled_wnd;

    // Scaled window, shift clamped to the legal maximum
    assign shift      = (cfg.window_scale > tar_pkg::MAX_WSCALE) ? tar_pkg::MAX_WSCALE
                                                                 : cfg.window_scale;
    assign scaled_wnd = {14'b0, seg.window_field} << shift;

    always_comb
    begin
        logic go_common;
        logic in_range;
        go_common = 1'b0;
        in_range  = 1'b0;
        nxt       = cur;
        res       = '0;
        res.action = tar_pkg::ACT_DROP;

        if (seg.operation == tar_pkg::OP_LOAD)
        begin
            // Load: only state and SND.UNA change
            if (seg.load_state inside {[tar_pkg::ST_CLOSED:tar_pkg::ST_TIME_WAIT]})
                nxt.tcp_state = seg.load_state;
            else
                nxt.tcp_state = tar_pkg::ST_CLOSED;
            nxt.snd_una = seg.ack_num;
        end
        else if (seg.ack_flag)
        begin
            // CE tracking
            if (seg.ecn_ce != cur.ce_seen)
            begin
                nxt.ce_seen = ~cur.ce_seen;
                res.ack_ece_request = 1'b1;
            end

            case (cur.tcp_state)
                tar_pkg::ST_SYN_RECV:
                begin
                    if (!(tar_pkg::seq_lt(cur.snd_una, seg.ack_num) &&
                          tar_pkg::seq_leq(seg.ack_num, seg.snd_next)))
                        res.action = tar_pkg::ACT_RTR;
                    else
                    begin
                        nxt.tcp_state = tar_pkg::ST_ESTAB;
                        nxt.snd_wnd   = scaled_wnd;
                        nxt.wl1       = seg.seq_num;
                        nxt.wl2       = seg.ack_num;
                        if (scaled_wnd > cur.wnd_max)
                            nxt.wnd_max = scaled_wnd;
                        if (cfg.passive_open && !seg.parent_present)
                        begin
                            res.action       = tar_pkg::ACT_RST;
                            res.release_conn = 1'b1;
                            nxt.tcp_state    = tar_pkg::ST_CLOSED;
                        end
                        else
                        begin
                            res.rto_reinit         = cfg.reinit_rto;
                            res.established_notify = 1'b1;
                            go_common              = 1'b1;
                        end
                    end
                end
                tar_pkg::ST_ESTAB, tar_pkg::ST_FIN_WAIT1, tar_pkg::ST_FIN_WAIT2,
                tar_pkg::ST_CLOSE_WAIT, tar_pkg::ST_CLOSING:
                    go_common = 1'b1;
                tar_pkg::ST_LAST_ACK:
                begin
                    if (tar_pkg::seq_leq(seg.snd_next, seg.ack_num))
                    begin
                        res.release_conn = 1'b1;
                        nxt.tcp_state    = tar_pkg::ST_CLOSED;
                    end
                end
                tar_pkg::ST_TIME_WAIT:
                begin
                    if (seg.fin_flag)
                    begin
                        res.action          = tar_pkg::ACT_ACK;
                        res.time_wait_timer = 1'b1;
                    end
                end
                default:
                    res.action = tar_pkg::ACT_DROP;
            endcase

            if (go_common)
            begin
                in_range = tar_pkg::seq_leq(seg.ack_num, seg.snd_next);

                // Window update (WL1/WL2 rule)
                if (tar_pkg::seq_leq(nxt.snd_una, seg.ack_num) && in_range &&
                    (tar_pkg::seq_lt(nxt.wl1, seg.seq_num) ||
                     (nxt.wl1 == seg.seq_num && tar_pkg::seq_leq(nxt.wl2, seg.ack_num))))
                begin
                    nxt.snd_wnd = scaled_wnd;
                    nxt.wl1     = seg.seq_num;
                    nxt.wl2     = seg.ack_num;
                    if (scaled_wnd > nxt.wnd_max)
                        nxt.wnd_max = scaled_wnd;
                end

                // New, duplicate or ahead-of-send ACK
                if (tar_pkg::seq_lt(nxt.snd_una, seg.ack_num) && in_range)
                begin
                    res.bytes_acked = seg.ack_num - nxt.snd_una;
                    res.clean_rtx   = 1'b1;
                    nxt.snd_una     = seg.ack_num;
                    res.action      = tar_pkg::ACT_PASS;
                    if (nxt.tcp_state == tar_pkg::ST_FIN_WAIT1)
                    begin
                        if (tar_pkg::seq_leq(seg.snd_next, seg.ack_num))
                            nxt.tcp_state = tar_pkg::ST_FIN_WAIT2;
                    end
                    else if (nxt.tcp_state == tar_pkg::ST_CLOSING)
                    begin
                        if (tar_pkg::seq_leq(seg.snd_next, seg.ack_num))
                        begin
                            nxt.tcp_state       = tar_pkg::ST_TIME_WAIT;
                            res.time_wait_timer = 1'b1;
                        end
                        res.action = tar_pkg::ACT_DROP;
                    end
                end
                else if (tar_pkg::seq_leq(seg.ack_num, nxt.snd_una))
                    res.action = tar_pkg::ACT_PASS;
                else
                    res.action = tar_pkg::ACT_ACK;
            end
        end

        res.conn_state      = nxt.tcp_state;
        res.send_window     = nxt.snd_wnd;
        res.send_window_max = nxt.wnd_max;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tcp_ack_receive_step.sv
// TCP ACK receive step for one connection: input register, step logic, result
// register and connection state. Depends on tar_pkg and tar_step.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one segment or load beat.
//   A load beat (operation = 1) writes the connection state and SND.UNA and
//   gives no result. A segment beat gives exactly one result beat on the
//   output channel (out_valid / out_stall).
//   A segment passes the input register and step logic into the result register.
//   Throughput: one beat per cycle while out_stall is low; the connection
//   state is read and written in the same cycle, so consecutive beats see
//   each other's update.
//   When out_stall holds a result, the next segment waits in the input
//   register and in_stall rises only once both registers are full.
//   Load beats advance even while the result register is held.
//   Configuration: cfg_wr_en writes register cfg_index with cfg_wdata at the
//   clock edge; index 3 is ignored. Write only while the block is idle.
//   Reset (rst_n low, asynchronous): both registers empty, connection state
//   closed, all sequence and window state and configuration zero.
`default_nettype none

module tcp_ack_receive_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic        ack_flag,
    input  wire logic        ecn_ce,
    input  wire logic        fin_flag,
    input  wire logic [31:0] seq_num,
    input  wire logic [31:0] ack_num,
    input  wire logic [15:0] window_field,
    input  wire logic [31:0] snd_next,
    input  wire logic        parent_present,
    input  wire logic [3:0]  load_state,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic             ack_ece_request,
    output logic [31:0]      bytes_acked,
    output logic [3:0]       conn_state,
    output logic [29:0]      send_window,
    output logic [29:0]      send_window_max,
    output logic             clean_rtx,
    output logic             time_wait_timer,
    output logic             release_conn,
    output logic             established_notify,
    output logic             rto_reinit
);

    tar_pkg::cfg_t    cfg_reg;
    tar_pkg::conn_t   conn_reg;
    tar_pkg::conn_t   conn_next;
    tar_pkg::seg_t    seg_reg;
    tar_pkg::result_t res_reg;
    tar_pkg::result_t res_next;
    logic             in_v_reg;
    logic             out_v_reg;
    logic             is_load;
    logic             advance;
    logic             out_take;

    // Handshake control
    assign is_load  = (seg_reg.operation == tar_pkg::OP_LOAD);
    assign out_take = out_v_reg && !out_stall;
    assign advance  = in_v_reg && (is_load || !out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tar_pkg::CFG_WINDOW_SCALE: cfg_reg.window_scale <= cfg_wdata;
                tar_pkg::CFG_PASSIVE_OPEN: cfg_reg.passive_open <= cfg_wdata[0];
                tar_pkg::CFG_REINIT_RTO:   cfg_reg.reinit_rto   <= cfg_wdata[0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (!in_stall)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            seg_reg.operation      <= operation;
            seg_reg.ack_flag       <= ack_flag;
            seg_reg.ecn_ce         <= ecn_ce;
            seg_reg.fin_flag       <= fin_flag;
            seg_reg.seq_num        <= seq_num;
            seg_reg.ack_num        <= ack_num;
            seg_reg.window_field   <= window_field;
            seg_reg.snd_next       <= snd_next;
            seg_reg.parent_present <= parent_present;
            seg_reg.load_state     <= load_state;
        end
    end

    tar_step u_step (
        .cfg (cfg_reg),
        .cur (conn_reg),
        .seg (seg_reg),
        .nxt (conn_next),
        .res (res_next)
    );

    // Connection state; all zero is the closed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conn_reg <= '0;
        else if (advance)
            conn_reg <= conn_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance && !is_load)
            out_v_reg <= 1'b1;
        else if (out_take)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && !is_load)
            res_reg <= res_next;
    end

    assign out_valid          = out_v_reg;
    assign action             = res_reg.action;
    assign ack_ece_request    = res_reg.ack_ece_request;
    assign bytes_acked        = res_reg.bytes_acked;
    assign conn_state         = res_reg.conn_state;
    assign send_window        = res_reg.send_window;
    assign send_window_max    = res_reg.send_window_max;
    assign clean_rtx          = res_reg.clean_rtx;
    assign time_wait_timer    = res_reg.time_wait_timer;
    assign release_conn       = res_reg.release_conn;
    assign established_notify = res_reg.established_notify;
    assign rto_reinit         = res_reg.rto_reinit;

    // Checks
    a_seg_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_load) |=> out_v_reg)
        else $error("segment beat did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_v_reg && out_v_reg && out_stall && !is_load))
        else $error("input stalled while the result register could move");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_stall) |=> $stable(res_reg))
        else $error("held result changed");

    a_release_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && res_reg.release_conn) |-> (res_reg.conn_state == tar_pkg::ST_CLOSED))
        else $error("release without closed state");

    a_acked_cleans: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && res_reg.bytes_acked != 32'd0) |-> res_reg.clean_rtx)
        else $error("bytes acked without retransmit clean");

endmodule

`default_nettype wire

FILE: sim/tb_tcp_ack_receive_step.sv
// Self-checking testbench for tcp_ack_receive_step: directed and random segment and load
// beats, checked against a behavioral model of the connection held in this file.
// Depends on tar_pkg and the tcp_ack_receive_step RTL.
`timescale 1ns / 1ps

module tb_tcp_ack_receive_step;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 6;
    localparam logic [3:0] BAD_STATE = 4'd12;

    typedef struct {
        tar_pkg::seg_t seg;
        bit            drain_first;   // wait for every pending result before offering
    } beat_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic        ack_flag = 1'b0;
    logic        ecn_ce = 1'b0;
    logic        fin_flag = 1'b0;
    logic [31:0] seq_num = '0;
    logic [31:0] ack_num = '0;
    logic [15:0] window_field = '0;
    logic [31:0] snd_next = '0;
    logic        parent_present = 1'b0;
    logic [3:0]  load_state = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic        ack_ece_request;
    logic [31:0] bytes_acked;
    logic [3:0]  conn_state;
    logic [29:0] send_window;
    logic [29:0] send_window_max;
    logic        clean_rtx;
    logic        time_wait_timer;
    logic        release_conn;
    logic        established_notify;
    logic        rto_reinit;

    tcp_ack_receive_step DUT (.*);

    // Stimulus and expectation stores
    beat_t            segment_q[$];
    tar_pkg::result_t ack_results_q[$];

    // Predicted configuration and connection state
    logic [3:0]  cfg_scale = '0;
    logic        cfg_passive = 1'b0;
    logic        cfg_reinit = 1'b0;
    logic [3:0]  p_state = tar_pkg::ST_CLOSED;
    logic [31:0] p_una = '0;
    logic [29:0] p_wnd = '0;
    logic [31:0] p_wl1 = '0;
    logic [31:0] p_wl2 = '0;
    logic [29:0] p_wmax = '0;
    logic        p_ce = 1'b0;

    // Run control and bookkeeping
    bit          burst_mode = 1'b0;
    bit          hold_req = 1'b0;
    logic        hold_on = 1'b0;
    int          hold_left = 0;
    int          error_count = 0;
    int          seg_count = 0;
    int          load_count = 0;
    int          result_count = 0;
    int          cycle_count = 0;
    logic [31:0] seq_cursor = 32'h1000;
    logic        ce_level = 1'b0;

    // Driver and monitor working variables
    tar_pkg::seg_t    cur_seg;
    beat_t            next_beat;
    int               gap_left = 0;
    int               s_calm_left = 0;
    int               stall_left = 0;
    int               r_calm_left = 0;
    tar_pkg::result_t got;
    tar_pkg::result_t want;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sequence-space compares, modulo 2^32
    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic seq_not_after(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_before(a, b);
    endfunction

    // Latch a new send window and its WL1/WL2 marks
    task automatic latch_window(input logic [15:0] win, input logic [31:0] seq,
                                input logic [31:0] ack);
        logic [3:0] sh;
        sh = (cfg_scale > tar_pkg::MAX_WSCALE) ? tar_pkg::MAX_WSCALE : cfg_scale;
        p_wnd = {14'd0, win} << sh;
        p_wl1 = seq;
        p_wl2 = ack;
        if (p_wnd > p_wmax)
            p_wmax = p_wnd;
    endtask

    // Apply one accepted beat to the predicted connection; segments queue a result
    task automatic advance_connection(input tar_pkg::seg_t s);
        tar_pkg::result_t r;
        logic             common;
        r = '0;
        common = 1'b0;
        if (s.operation == tar_pkg::OP_LOAD)
        begin
            p_state = (s.load_state > tar_pkg::ST_TIME_WAIT) ? tar_pkg::ST_CLOSED
                                                             : s.load_state;
            p_una = s.ack_num;
            return;
        end
        r.action = tar_pkg::ACT_DROP;
        if (s.ack_flag)
        begin
            // CE change flips the tracked flag and asks for an ECE ack
            if (s.ecn_ce != p_ce)
            begin
                p_ce = ~p_ce;
                r.ack_ece_request = 1'b1;
            end
            if (p_state == tar_pkg::ST_SYN_RECV)
            begin
                if (!(seq_before(p_una, s.ack_num) && seq_not_after(s.ack_num, s.snd_next)))
                begin
                    r.action = tar_pkg::ACT_RTR;
                end
                else
                begin
                    p_state = tar_pkg::ST_ESTAB;
                    latch_window(s.window_field, s.seq_num, s.ack_num);
                    if (cfg_passive && !s.parent_present)
                    begin
                        r.action = tar_pkg::ACT_RST;
                        r.release_conn = 1'b1;
                        p_state = tar_pkg::ST_CLOSED;
                    end
                    else
                    begin
                        r.rto_reinit = cfg_reinit;
                        r.established_notify = 1'b1;
                        common = 1'b1;
                    end
                end
            end
            else if (p_state >= tar_pkg::ST_ESTAB && p_state <= tar_pkg::ST_CLOSING)
            begin
                common = 1'b1;
            end
            else if (p_state == tar_pkg::ST_LAST_ACK)
            begin
                if (seq_not_after(s.snd_next, s.ack_num))
                begin
                    r.release_conn = 1'b1;
                    p_state = tar_pkg::ST_CLOSED;
                end
            end
            else if (p_state == tar_pkg::ST_TIME_WAIT)
            begin
                if (s.fin_flag)
                begin
                    r.action = tar_pkg::ACT_ACK;
                    r.time_wait_timer = 1'b1;
                end
            end

            // Window update and ACK classification for synchronized states
            if (common)
            begin
                if (seq_not_after(p_una, s.ack_num) && seq_not_after(s.ack_num, s.snd_next))
                begin
                    if (seq_before(p_wl1, s.seq_num) ||
                        (p_wl1 == s.seq_num && seq_not_after(p_wl2, s.ack_num)))
                        latch_window(s.window_field, s.seq_num, s.ack_num);
                end
                if (seq_before(p_una, s.ack_num) && seq_not_after(s.ack_num, s.snd_next))
                begin
                    r.bytes_acked = s.ack_num - p_una;
                    r.clean_rtx = 1'b1;
                    p_una = s.ack_num;
                    r.action = tar_pkg::ACT_PASS;
                    if (p_state == tar_pkg::ST_FIN_WAIT1)
                    begin
                        if (seq_not_after(s.snd_next, s.ack_num))
                            p_state = tar_pkg::ST_FIN_WAIT2;
                    end
                    else if (p_state == tar_pkg::ST_CLOSING)
                    begin
                        if (seq_not_after(s.snd_next, s.ack_num))
                        begin
                            p_state = tar_pkg::ST_TIME_WAIT;
                            r.time_wait_timer = 1'b1;
                        end
                        r.action = tar_pkg::ACT_DROP;
                    end
                end
                else if (seq_not_after(s.ack_num, p_una))
                begin
                    r.action = tar_pkg::ACT_PASS;
                end
                else
                begin
                    r.action = tar_pkg::ACT_ACK;
                end
            end
        end
        r.conn_state = p_state;
        r.send_window = p_wnd;
        r.send_window_max = p_wmax;
        ack_results_q.insert(ack_results_q.size(), r);
    endtask

    // Stimulus builders
    task automatic push_seg(input logic af, input logic ce, input logic fin,
                            input logic [31:0] seq, input logic [31:0] ack,
                            input logic [15:0] win, input logic [31:0] nxt,
                            input logic parent);
        beat_t b;
        b.drain_first = 1'b0;
        b.seg.operation = tar_pkg::OP_SEGMENT;
        b.seg.ack_flag = af;
        b.seg.ecn_ce = ce;
        b.seg.fin_flag = fin;
        b.seg.seq_num = seq;
        b.seg.ack_num = ack;
        b.seg.window_field = win;
        b.seg.snd_next = nxt;
        b.seg.parent_present = parent;
        b.seg.load_state = 4'($urandom_range(0, 15));
        segment_q.insert(segment_q.size(), b);
    endtask

    task automatic push_load(input logic [3:0] st, input logic [31:0] una);
        beat_t b;
        b.drain_first = 1'b0;
        b.seg.operation = tar_pkg::OP_LOAD;
        b.seg.ack_flag = 1'($urandom_range(0, 1));
        b.seg.ecn_ce = 1'($urandom_range(0, 1));
        b.seg.fin_flag = 1'($urandom_range(0, 1));
        b.seg.seq_num = $urandom;
        b.seg.ack_num = una;
        b.seg.window_field = 16'($urandom);
        b.seg.snd_next = $urandom;
        b.seg.parent_present = 1'($urandom_range(0, 1));
        b.seg.load_state = st;
        segment_q.insert(segment_q.size(), b);
    endtask

    // One connection episode: load a state and SND.UNA, then a short run of segments
    task automatic push_scenario();
        logic [3:0]  st;
        logic [31:0] una;
        logic [31:0] nxt;
        logic [31:0] cur;
        logic [31:0] ack;
        logic [31:0] seq;
        logic [15:0] win;
        int          pick;
        int          n;
        int          kind;
        pick = $urandom_range(0, 19);
        if (pick < 5)       st = tar_pkg::ST_SYN_RECV;
        else if (pick < 8)  st = tar_pkg::ST_ESTAB;
        else if (pick < 10) st = tar_pkg::ST_FIN_WAIT1;
        else if (pick < 11) st = tar_pkg::ST_FIN_WAIT2;
        else if (pick < 12) st = tar_pkg::ST_CLOSE_WAIT;
        else if (pick < 14) st = tar_pkg::ST_CLOSING;
        else if (pick < 16) st = tar_pkg::ST_LAST_ACK;
        else if (pick < 18) st = tar_pkg::ST_TIME_WAIT;
        else if (pick < 19) st = tar_pkg::ST_CLOSED;
        else                st = 4'($urandom_range(9, 15));
        case ($urandom_range(0, 5))
            0:       una = 32'hFFFF_FF00 + $urandom_range(0, 255);
            1:       una = 32'd0;
            default: una = $urandom;
        endcase
        if ($urandom_range(0, 5) == 0)
            nxt = una + $urandom_range(0, 32'h7FFF_FFFF);
        else
            nxt = una + $urandom_range(0, 3000);
        cur = una;
        push_load(st, una);
        if ($urandom_range(0, 15) == 0)
            seq_cursor = $urandom;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                ack = cur + $urandom_range(0, nxt - cur);
                cur = ack;
            end
            else if (kind == 5)
            begin
                ack = nxt;
                cur = nxt;
            end
            else if (kind == 6)
            begin
                ack = cur;
            end
            else if (kind == 7)
            begin
                ack = cur - $urandom_range(1, 1000);
            end
            else if (kind == 8)
            begin
                ack = nxt + $urandom_range(1, 1000);
            end
            else
            begin
                ack = $urandom;
            end
            // mostly advancing sequence numbers, sometimes repeated or old
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                seq_cursor = seq_cursor + $urandom_range(0, 1460);
                seq = seq_cursor;
            end
            else if (pick < 9)
            begin
                seq = seq_cursor;
            end
            else
            begin
                seq = seq_cursor - $urandom_range(1, 5000);
            end
            case ($urandom_range(0, 7))
                0:       win = 16'h0000;
                1:       win = 16'hFFFF;
                default: win = 16'($urandom);
            endcase
            if ($urandom_range(0, 4) == 0)
                ce_level = ~ce_level;
            push_seg(1'($urandom_range(0, 11) != 0), ce_level, 1'($urandom_range(0, 4) == 0),
                     seq, ack, win, nxt, 1'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 2) == 0)
                nxt = nxt + $urandom_range(0, 500);
        end
    endtask

    // Random beats: mostly episodes, some raw noise
    task automatic push_random(input int count);
        int    start;
        beat_t b;
        start = segment_q.size();
        while (segment_q.size() - start < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b.drain_first = 1'b0;
                b.seg.operation = 1'($urandom_range(0, 1));
                b.seg.ack_flag = 1'($urandom_range(0, 1));
                b.seg.ecn_ce = 1'($urandom_range(0, 1));
                b.seg.fin_flag = 1'($urandom_range(0, 1));
                b.seg.seq_num = $urandom;
                b.seg.ack_num = $urandom;
                b.seg.window_field = 16'($urandom);
                b.seg.snd_next = $urandom;
                b.seg.parent_present = 1'($urandom_range(0, 1));
                b.seg.load_state = 4'($urandom_range(0, 15));
                segment_q.insert(segment_q.size(), b);
            end
            else
            begin
                push_scenario();
            end
        end
    endtask

    // Write all three registers on consecutive edges
    task automatic apply_settings(input logic [3:0] scale, input logic passive,
                                  input logic reinit);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tar_pkg::CFG_WINDOW_SCALE;
        cfg_wdata <= scale;
        @(posedge clk);
        cfg_index <= tar_pkg::CFG_PASSIVE_OPEN;
        cfg_wdata <= {3'd0, passive};
        @(posedge clk);
        cfg_index <= tar_pkg::CFG_REINIT_RTO;
        cfg_wdata <= {3'd0, reinit};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_scale = scale;
        cfg_passive = passive;
        cfg_reinit = reinit;
        @(negedge clk);
    endtask

    // Block is idle once all beats are in, all results are out and loads have drained
    task automatic wait_idle();
        while (segment_q.size() != 0 || in_valid || ack_results_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Driver: one beat at a time from segment_q, random gap per beat outside burst mode and calm runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            s_calm_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_connection(cur_seg);
                if (cur_seg.operation == tar_pkg::OP_LOAD)
                    load_count++;
                else
                    seg_count++;
                if (burst_mode)
                begin
                    gap_left = 0;
                end
                else if (s_calm_left > 0)
                begin
                    s_calm_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    s_calm_left = $urandom_range(20, 60);
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 10);
                end
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (segment_q.size() != 0 &&
                         !(segment_q[0].drain_first && ack_results_q.size() != 0))
                begin
                    next_beat = segment_q.pop_front();
                    cur_seg = next_beat.seg;
                    operation <= cur_seg.operation;
                    ack_flag <= cur_seg.ack_flag;
                    ecn_ce <= cur_seg.ecn_ce;
                    fin_flag <= cur_seg.fin_flag;
                    seq_num <= cur_seg.seq_num;
                    ack_num <= cur_seg.ack_num;
                    window_field <= cur_seg.window_field;
                    snd_next <= cur_seg.snd_next;
                    parent_present <= cur_seg.parent_present;
                    load_state <= cur_seg.load_state;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_on <= 1'b1;
            end
            else
            begin
                hold_on <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat, then draw the stall before the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            r_calm_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {action, ack_ece_request, bytes_acked, conn_state, send_window,
                       send_window_max, clean_rtx, time_wait_timer, release_conn,
                       established_notify, rto_reinit};
                result_count++;
                if (ack_results_q.size() == 0)
                begin
                    $error("result beat with no pending expectation");
                    error_count++;
                end
                else
                begin
                    want = ack_results_q.pop_front();
                    if (got.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, got.action);
                        error_count++;
                    end
                    if (got.ack_ece_request !== want.ack_ece_request)
                    begin
                        $error("ack_ece_request: expected %0d, got %0d",
                               want.ack_ece_request, got.ack_ece_request);
                        error_count++;
                    end
                    if (got.bytes_acked !== want.bytes_acked)
                    begin
                        $error("bytes_acked: expected %0d, got %0d",
                               want.bytes_acked, got.bytes_acked);
                        error_count++;
                    end
                    if (got.conn_state !== want.conn_state)
                    begin
                        $error("conn_state: expected %0d, got %0d",
                               want.conn_state, got.conn_state);
                        error_count++;
                    end
                    if (got.send_window !== want.send_window)
                    begin
                        $error("send_window: expected %0d, got %0d",
                               want.send_window, got.send_window);
                        error_count++;
                    end
                    if (got.send_window_max !== want.send_window_max)
                    begin
                        $error("send_window_max: expected %0d, got %0d",
                               want.send_window_max, got.send_window_max);
                        error_count++;
                    end
                    if (got.clean_rtx !== want.clean_rtx)
                    begin
                        $error("clean_rtx: expected %0d, got %0d",
                               want.clean_rtx, got.clean_rtx);
                        error_count++;
                    end
                    if (got.time_wait_timer !== want.time_wait_timer)
                    begin
                        $error("time_wait_timer: expected %0d, got %0d",
                               want.time_wait_timer, got.time_wait_timer);
                        error_count++;
                    end
                    if (got.release_conn !== want.release_conn)
                    begin
                        $error("release_conn: expected %0d, got %0d",
                               want.release_conn, got.release_conn);
                        error_count++;
                    end
                    if (got.established_notify !== want.established_notify)
                    begin
                        $error("established_notify: expected %0d, got %0d",
                               want.established_notify, got.established_notify);
                        error_count++;
                    end
                    if (got.rto_reinit !== want.rto_reinit)
                    begin
                        $error("rto_reinit: expected %0d, got %0d",
                               want.rto_reinit, got.rto_reinit);
                        error_count++;
                    end
                end
                if (r_calm_left > 0)
                begin
                    r_calm_left--;
                    stall_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    r_calm_left = $urandom_range(20, 60);
                    stall_left = 0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 10);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= hold_on;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, ack_results_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence: reset, then one stimulus phase per register setting
    initial
    begin
        int idx;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: scale above the cap, active open, RTO reinit on
        apply_settings(4'd15, 1'b0, 1'b1);
        push_seg(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        push_seg(1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 16'h0000, 32'd0, 1'b0);
        push_load(tar_pkg::ST_SYN_RECV, 32'd100);
        push_seg(1'b1, 1'b0, 1'b0, 32'd1000, 32'd100, 16'h1234, 32'd200, 1'b1);
        push_seg(1'b1, 1'b0, 1'b0, 32'd1000, 32'd150, 16'hFFFF, 32'd200, 1'b1);
        push_seg(1'b1, 1'b0, 1'b0, 32'd1000, 32'd150, 16'h0000, 32'd200, 1'b1);
        push_seg(1'b1, 1'b1, 1'b0, 32'd1001, 32'd250, 16'h0010, 32'd200, 1'b0);
        push_seg(1'b1, 1'b1, 1'b1, 32'd1002, 32'd200, 16'h0100, 32'd200, 1'b0);
        // FIN_WAIT1 across the sequence wrap
        push_load(tar_pkg::ST_FIN_WAIT1, 32'hFFFF_FFF0);
        push_seg(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd5, 16'd1, 32'd10, 1'b1);
        push_seg(1'b1, 1'b1, 1'b0, 32'd0, 32'd10, 16'd2, 32'd10, 1'b1);
        // CLOSING: partial ack still drops, full ack enters TIME_WAIT
        push_load(tar_pkg::ST_CLOSING, 32'd50);
        push_seg(1'b1, 1'b0, 1'b0, 32'd5, 32'd55, 16'd3, 32'd60, 1'b1);
        push_seg(1'b1, 1'b0, 1'b0, 32'd6, 32'd60, 16'd4, 32'd60, 1'b1);
        push_seg(1'b1, 1'b0, 1'b1, 32'd7, 32'd60, 16'd5, 32'd60, 1'b1);
        push_seg(1'b1, 1'b0, 1'b0, 32'd8, 32'd60, 16'd6, 32'd60, 1'b1);
        // LAST_ACK partial, then final ack releases
        push_load(tar_pkg::ST_LAST_ACK, 32'd0);
        push_seg(1'b1, 1'b0, 1'b0, 32'd9, 32'd5, 16'd7, 32'd10, 1'b1);
        push_seg(1'b1, 1'b0, 1'b1, 32'd10, 32'd10, 16'd8, 32'd10, 1'b1);
        // out-of-range load state reads back as closed
        push_load(BAD_STATE, 32'd7);
        push_seg(1'b1, 1'b1, 1'b0, 32'd11, 32'd8, 16'd9, 32'd9, 1'b1);
        // old ack at the top of sequence space
        push_load(tar_pkg::ST_CLOSE_WAIT, 32'd0);
        push_seg(1'b1, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b1);
        wait_idle();

        // passive open: lost parent resets, present parent establishes
        apply_settings(4'd0, 1'b1, 1'b0);
        push_load(tar_pkg::ST_SYN_RECV, 32'd500);
        push_seg(1'b1, 1'b0, 1'b0, 32'd20, 32'd600, 16'h8000, 32'd700, 1'b0);
        push_load(tar_pkg::ST_SYN_RECV, 32'd500);
        push_seg(1'b1, 1'b0, 1'b0, 32'd21, 32'd600, 16'h8000, 32'd700, 1'b1);
        push_random(250);
        wait_idle();

        // maximum scale; back-to-back offers against a long receiver hold-off
        apply_settings(tar_pkg::MAX_WSCALE, 1'b1, 1'b1);
        burst_mode = 1'b1;
        hold_req = 1'b1;
        push_random(250);
        wait_idle();
        burst_mode = 1'b0;

        // mid scale; sender pauses for a full drain in the middle
        apply_settings(4'd7, 1'b0, 1'b1);
        push_random(150);
        idx = segment_q.size();
        push_random(150);
        segment_q[idx].drain_first = 1'b1;
        wait_idle();

        // random scale and open mode
        apply_settings(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0);
        push_random(300);
        wait_idle();

        if (ack_results_q.size() != 0)
        begin
            $error("%0d expected results never arrived", ack_results_q.size());
            error_count++;
        end
        $display("Drove %0d segment beats and %0d load beats; checked %0d results.",
                 seg_count, load_count, result_count);
        $display("Five register settings, a long output hold-off and a full drain pause.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
